FILE: sv/lbp3d_pkg.sv
// Shared constants, types and field widths of the 3D-LBP window encoder.
// Used by every module of the block; depends on nothing else.
package lbp3d_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 4096;
	localparam int PIX_W       = 8;
	localparam int ADDR_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int COL_W       = ADDR_W;
	localparam int WIDTH_W     = 12;
	localparam int CODE_W      = 8;
	localparam int MAG_W       = 3;
	localparam int OUT_DATA_W  = 56;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
	localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(3);
	localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(MAX_HEIGHT - 1);
	localparam logic [MAG_W-1:0]   MAG_SAT     = MAG_W'(7);

	typedef logic [PIX_W-1:0] pix_t;

	// Position and emit flag of one pixel as it moves down the pipeline.
	typedef struct packed {
		logic             emit;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} meta_t;

	typedef struct packed {
		logic [COL_W-1:0]  center_col;
		logic [ROW_W-1:0]  center_row;
		logic [CODE_W-1:0] mag_low_code;
		logic [CODE_W-1:0] mag_mid_code;
		logic [CODE_W-1:0] mag_high_code;
		logic [CODE_W-1:0] sign_code;
	} result_t;

endpackage

FILE: sv/lbp3d_line_store.sv
// Two line stores (the rows two above and one above the current pixel).
// Synchronous, registered read, with forwarding of a same-cycle write.
// Depends on lbp3d_pkg.
module lbp3d_line_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [lbp3d_pkg::ADDR_W-1:0] rd_addr,
	input  logic                        wr_en,
	input  logic [lbp3d_pkg::ADDR_W-1:0] wr_addr,
	input  lbp3d_pkg::pix_t             wr_upper,
	input  lbp3d_pkg::pix_t             wr_lower,
	output lbp3d_pkg::pix_t             rd_upper,
	output lbp3d_pkg::pix_t             rd_lower
);

	lbp3d_pkg::pix_t mem_upper [lbp3d_pkg::MAX_WIDTH];
	lbp3d_pkg::pix_t mem_lower [lbp3d_pkg::MAX_WIDTH];

	lbp3d_pkg::pix_t upper_q;
	lbp3d_pkg::pix_t lower_q;
	lbp3d_pkg::pix_t fwd_upper_q;
	lbp3d_pkg::pix_t fwd_lower_q;
	logic            fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_upper[wr_addr] <= wr_upper;
			mem_lower[wr_addr] <= wr_lower;
		end
		if (rd_en) begin
			upper_q     <= mem_upper[rd_addr];
			lower_q     <= mem_lower[rd_addr];
			fwd_upper_q <= wr_upper;
			fwd_lower_q <= wr_lower;
		end
	end

	// The array returns the old entry when it is written in the same cycle,
	// so the fresh write data is kept aside and used instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_upper = fwd_q ? fwd_upper_q : upper_q;
	assign rd_lower = fwd_q ? fwd_lower_q : lower_q;

endmodule

FILE: sv/lbp3d_window.sv
// 3x3 window, code computation and the output register with its handshake.
// Depends on lbp3d_pkg.
module lbp3d_window (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift_valid,
	output logic                    shift_ready,
	input  lbp3d_pkg::pix_t         col_top,
	input  lbp3d_pkg::pix_t         col_mid,
	input  lbp3d_pkg::pix_t         col_bot,
	input  lbp3d_pkg::meta_t        meta_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output lbp3d_pkg::result_t      out_result
);

	// Clockwise ring from the top-left; the first neighbour is the MSB.
	localparam logic [1:0] RING_R [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};
	localparam logic [1:0] RING_C [8] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};

	lbp3d_pkg::pix_t    window_q [3][3];
	lbp3d_pkg::meta_t   meta_s2;
	logic               valid_s2;
	logic               out_valid_q;
	lbp3d_pkg::result_t result_q;
	lbp3d_pkg::result_t result_d;
	logic               out_en;
	logic               s2_free;

	assign out_en      = !out_valid_q || out_ready;
	assign s2_free     = !valid_s2 || !meta_s2.emit || out_en;
	assign shift_ready = s2_free;

	always_comb begin
		lbp3d_pkg::pix_t          nb;
		lbp3d_pkg::pix_t          ce;
		lbp3d_pkg::pix_t          diff;
		logic [lbp3d_pkg::MAG_W-1:0] mag;
		ce       = window_q[1][1];
		result_d = '0;
		for (int i = 0; i < 8; i++) begin
			nb   = window_q[RING_R[i]][RING_C[i]];
			diff = (nb > ce) ? nb - ce : ce - nb;
			mag  = (|diff[lbp3d_pkg::PIX_W-1:lbp3d_pkg::MAG_W]) ? lbp3d_pkg::MAG_SAT
				: diff[lbp3d_pkg::MAG_W-1:0];
			result_d.sign_code[7-i]     = nb > ce;
			result_d.mag_high_code[7-i] = mag[2];
			result_d.mag_mid_code[7-i]  = mag[1];
			result_d.mag_low_code[7-i]  = mag[0];
		end
		result_d.center_row = meta_s2.row;
		result_d.center_col = meta_s2.col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					window_q[r][c] <= '0;
				end
			end
			valid_s2    <= 1'b0;
			meta_s2     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (shift_valid && s2_free) begin
				for (int r = 0; r < 3; r++) begin
					window_q[r][0] <= window_q[r][1];
					window_q[r][1] <= window_q[r][2];
				end
				window_q[0][2] <= col_top;
				window_q[1][2] <= col_mid;
				window_q[2][2] <= col_bot;
				valid_s2       <= 1'b1;
				meta_s2        <= meta_in;
			end else if (s2_free) begin
				valid_s2 <= 1'b0;
			end
			if (out_en) begin
				out_valid_q <= valid_s2 && meta_s2.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2 && meta_s2.emit) begin
			result_q <= result_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = result_q;

endmodule

FILE: sv/lbp3d_window_encoder.sv
// Top level of the streaming 3D local binary pattern encoder (3x3 window).
// Depends on lbp3d_pkg, lbp3d_line_store and lbp3d_window.
//
// Channel   Direction  Signals                       Contents
// s_axis    in         tvalid tready tdata tuser     pixel; tuser = frame_start
// m_axis    out        tvalid tready tdata           four codes, center row/col
// cfg       in         cfg_wr_en cfg_wr_data         image_width (12 bits)
//
// One pixel transaction per clock while m_axis keeps up; a result passes the line store
// read in stage 1, then the window register, then the output register. Reset clears
// counters, valid flags and the window and loads a width of 640; the line stores keep
// old data, which rows 0 and 1 of a frame overwrite before it is used. On a stall the
// output, the window and stage 1 each hold one item, and s_axis_tready falls with
// m_axis_tready once all are full.
module lbp3d_window_encoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [7:0]                            s_axis_tdata,  // [7:0] pixel
	input  logic                                  s_axis_tuser,  // [0] frame_start
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [7:0] sign_code, [15:8] mag_high_code, [23:16] mag_mid_code,
	// [31:24] mag_low_code, [43:32] center_row, [54:44] center_col, [55] zero
	output logic [lbp3d_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                  cfg_wr_en,
	input  logic [lbp3d_pkg::WIDTH_W-1:0]         cfg_wr_data
);

	logic [lbp3d_pkg::WIDTH_W-1:0] width_q;
	logic [lbp3d_pkg::WIDTH_W-1:0] width_eff;
	logic [lbp3d_pkg::COL_W-1:0]   col_q;
	logic [lbp3d_pkg::ROW_W-1:0]   row_q;
	logic [lbp3d_pkg::COL_W-1:0]   col_cur;
	logic [lbp3d_pkg::ROW_W-1:0]   row_cur;
	logic                          row_end;
	logic                          accept;

	logic                          valid_s1;
	logic [lbp3d_pkg::ADDR_W-1:0]  addr_s1;
	lbp3d_pkg::pix_t               pix_s1;
	lbp3d_pkg::meta_t              meta_s1;
	lbp3d_pkg::meta_t              meta_cur;

	lbp3d_pkg::pix_t               rd_upper;
	lbp3d_pkg::pix_t               rd_lower;
	logic                          win_ready;
	logic                          s1_en;
	logic                          s1_move;
	lbp3d_pkg::result_t            result;

	// Widths outside the supported range are clamped.
	always_comb begin
		priority if (width_q < lbp3d_pkg::WIDTH_MIN) begin
			width_eff = lbp3d_pkg::WIDTH_MIN;
		end else if (width_q > lbp3d_pkg::WIDTH_MAX) begin
			width_eff = lbp3d_pkg::WIDTH_MAX;
		end else begin
			width_eff = width_q;
		end
	end

	// A frame_start pixel sits at row 0, column 0 whatever the counters say.
	assign col_cur = s_axis_tuser ? '0 : col_q;
	assign row_cur = s_axis_tuser ? '0 : row_q;
	assign row_end = ({1'b0, col_cur} + lbp3d_pkg::WIDTH_W'(1)) >= width_eff;

	always_comb begin
		meta_cur.emit = (row_cur >= lbp3d_pkg::ROW_W'(2))
			&& (col_cur >= lbp3d_pkg::COL_W'(2));
		meta_cur.row  = row_cur - lbp3d_pkg::ROW_W'(1);
		meta_cur.col  = col_cur - lbp3d_pkg::COL_W'(1);
	end

	// Stage 1 holds a pixel while its line store read completes; it moves on
	// into the window as soon as the window stage can take it.
	assign s1_en         = !valid_s1 || win_ready;
	assign s1_move       = valid_s1 && win_ready;
	assign s_axis_tready = s1_en;
	assign accept        = s_axis_tvalid && s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lbp3d_pkg::WIDTH_RESET;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				width_q <= cfg_wr_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				if (row_end) begin
					col_q <= '0;
					row_q <= (row_cur == lbp3d_pkg::ROW_LAST) ? '0
						: row_cur + lbp3d_pkg::ROW_W'(1);
				end else begin
					col_q <= col_cur + lbp3d_pkg::COL_W'(1);
					row_q <= row_cur;
				end
			end else if (s1_en) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_cur;
			pix_s1  <= s_axis_tdata;
			meta_s1 <= meta_cur;
		end
	end

	// Each column entry is read, then rewritten when its pixel enters the
	// window: the upper store takes the old lower value, the lower store the
	// new pixel.
	lbp3d_line_store u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (col_cur),
		.wr_en    (s1_move),
		.wr_addr  (addr_s1),
		.wr_upper (rd_lower),
		.wr_lower (pix_s1),
		.rd_upper (rd_upper),
		.rd_lower (rd_lower)
	);

	lbp3d_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift_valid (valid_s1),
		.shift_ready (win_ready),
		.col_top     (rd_upper),
		.col_mid     (rd_lower),
		.col_bot     (pix_s1),
		.meta_in     (meta_s1),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_result  (result)
	);

	assign m_axis_tdata = {1'b0, result};

endmodule

FILE: verif/lbp3d_code_checker.sv
// Scoreboard for the 3D-LBP window encoder: predicts the codes that the pixels
// accepted on s_axis produce and compares them with the transactions seen on m_axis.
// Depends on lbp3d_pkg for widths and the result layout.
`timescale 1ns / 100ps

module lbp3d_code_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // [7:0] pixel
	input  logic                             s_axis_tuser,  // [0] frame_start
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] sign, [15:8] mag high, [23:16] mag mid, [31:24] mag low,
	// [43:32] center_row, [54:44] center_col
	input  logic [lbp3d_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_wr_en,
	input  logic [lbp3d_pkg::WIDTH_W-1:0]    cfg_wr_data,
	output int                               due_count,
	output int                               errors
);

	logic [lbp3d_pkg::WIDTH_W-1:0] width_reg;
	lbp3d_pkg::pix_t               upper_line [lbp3d_pkg::MAX_WIDTH];
	lbp3d_pkg::pix_t               lower_line [lbp3d_pkg::MAX_WIDTH];
	lbp3d_pkg::pix_t               win [3][3];
	logic [lbp3d_pkg::COL_W-1:0]   col_pos;
	logic [lbp3d_pkg::ROW_W-1:0]   row_pos;
	lbp3d_pkg::result_t            codes_due [$];

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// Moves one pixel through the line stores and the window, and queues
	// the codes when the window sits on an interior pixel.
	task automatic encode_pixel(input lbp3d_pkg::pix_t px, input logic fs);
		int unsigned        span;
		int unsigned        r;
		int unsigned        c;
		int unsigned        mag;
		lbp3d_pkg::pix_t    ctr;
		lbp3d_pkg::pix_t    ring [8];
		lbp3d_pkg::result_t res;
		if (width_reg < lbp3d_pkg::WIDTH_MIN)
			span = lbp3d_pkg::WIDTH_MIN;
		else if (width_reg > lbp3d_pkg::WIDTH_MAX)
			span = lbp3d_pkg::MAX_WIDTH;
		else
			span = width_reg;
		if (fs) begin
			col_pos = '0;
			row_pos = '0;
		end
		r = row_pos;
		c = col_pos;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = upper_line[c];
		win[1][2] = lower_line[c];
		win[2][2] = px;
		upper_line[c] = lower_line[c];
		lower_line[c] = px;
		if (r >= 2 && c >= 2) begin
			ctr = win[1][1];
			// Clockwise from the top-left; the first neighbour lands in bit 7.
			ring = '{win[0][0], win[0][1], win[0][2], win[1][2],
				win[2][2], win[2][1], win[2][0], win[1][0]};
			res = '0;
			for (int i = 0; i < 8; i++) begin
				mag = (ring[i] > ctr) ? ring[i] - ctr : ctr - ring[i];
				if (mag > lbp3d_pkg::MAG_SAT)
					mag = lbp3d_pkg::MAG_SAT;
				res.sign_code[7-i]     = ring[i] > ctr;
				res.mag_high_code[7-i] = mag[2];
				res.mag_mid_code[7-i]  = mag[1];
				res.mag_low_code[7-i]  = mag[0];
			end
			res.center_row = lbp3d_pkg::ROW_W'(r - 1);
			res.center_col = lbp3d_pkg::COL_W'(c - 1);
			codes_due.push_back(res);
		end
		if (c + 1 >= span) begin
			col_pos = '0;
			row_pos = (row_pos == lbp3d_pkg::ROW_LAST) ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = lbp3d_pkg::COL_W'(c + 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lbp3d_pkg::result_t want;
		lbp3d_pkg::result_t got;
		if (!arst_n) begin
			width_reg = lbp3d_pkg::WIDTH_RESET;
			col_pos   = '0;
			row_pos   = '0;
			foreach (win[i, j])
				win[i][j] = '0;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			codes_due.delete();
		end else begin
			// Outgoing results belong to older pixels, so they are retired first.
			if (m_axis_tvalid && m_axis_tready) begin
				if (codes_due.size() == 0) begin
					$error("result with no pixel waiting for it: tdata=%h", m_axis_tdata);
					errors++;
				end else begin
					want = codes_due.pop_front();
					got  = m_axis_tdata[$bits(lbp3d_pkg::result_t)-1:0];
					check_field("sign_code", 16'(want.sign_code), 16'(got.sign_code));
					check_field("mag_high_code", 16'(want.mag_high_code),
						16'(got.mag_high_code));
					check_field("mag_mid_code", 16'(want.mag_mid_code),
						16'(got.mag_mid_code));
					check_field("mag_low_code", 16'(want.mag_low_code),
						16'(got.mag_low_code));
					check_field("center_row", 16'(want.center_row), 16'(got.center_row));
					check_field("center_col", 16'(want.center_col), 16'(got.center_col));
				end
			end
			if (cfg_wr_en)
				width_reg = cfg_wr_data;
			if (s_axis_tvalid && s_axis_tready)
				encode_pixel(s_axis_tdata, s_axis_tuser);
		end
		due_count = codes_due.size();
	end

endmodule

FILE: verif/tb_lbp3d_window_encoder.sv
// Top of the 3D-LBP window encoder testbench: clock, reset, pixel stimulus,
// output back-pressure, watchdog and verdict. Depends on lbp3d_pkg, the
// encoder RTL and lbp3d_code_checker, which does all prediction and checking.
`timescale 1ns / 100ps

module tb_lbp3d_window_encoder;

	// A run fails when this many cycles in a row pass with no transaction on
	// either stream. Random gaps and stalls, and the pauses around register
	// writes, all stay far shorter than that.
	localparam int QUIET_LIMIT = 1000;
	// Cycles to wait after the last expected result, covering the three-stage
	// pipeline with margin so that a stray late result is still caught.
	localparam int SETTLE_CYCLES = 6;

	// Pixel textures: fully random, smooth around a base level so that the
	// small magnitudes below saturation all show up, or only black and white.
	typedef enum int {TEXTURE_NOISE, TEXTURE_SMOOTH, TEXTURE_RAIL} texture_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [7:0]                       s_axis_tdata = '0;  // [7:0] pixel
	logic                             s_axis_tuser = 1'b0;  // [0] frame_start
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// [7:0] sign_code, [15:8] mag_high_code, [23:16] mag_mid_code,
	// [31:24] mag_low_code, [43:32] center_row, [54:44] center_col
	logic [lbp3d_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                             cfg_wr_en = 1'b0;
	logic [lbp3d_pkg::WIDTH_W-1:0]    cfg_wr_data = '0;

	int  due_count;
	int  chk_errors;
	int  quiet_cycles = 0;
	// While set, neither side inserts idle cycles.
	bit  calm = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	lbp3d_window_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	lbp3d_code_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.due_count     (due_count),
		.errors        (chk_errors)
	);

	// The output side stalls about 18 percent of the time.
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 18);

	// Watchdog: any transaction on either stream restarts the count.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Offers one pixel, after random idle cycles unless calm is set, and returns
	// at the edge where its transaction completes. Ready is sampled on the falling
	// edge, where it has settled, so the decision never races the DUT.
	task automatic push_pixel(input lbp3d_pkg::pix_t px, input logic fs);
		bit taken;
		while (!calm && $urandom_range(99) < 18) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tuser  <= fs;
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Waits until every predicted result has come out and the pipeline has
	// emptied, then writes the width register while the block is idle.
	task automatic write_width(input logic [lbp3d_pkg::WIDTH_W-1:0] w);
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (due_count != 0);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int unsigned span_of(input int unsigned w);
		if (w < lbp3d_pkg::WIDTH_MIN)
			return lbp3d_pkg::WIDTH_MIN;
		if (w > lbp3d_pkg::MAX_WIDTH)
			return lbp3d_pkg::MAX_WIDTH;
		return w;
	endfunction

	function automatic lbp3d_pkg::pix_t pick_pixel(input texture_t tex,
			input lbp3d_pkg::pix_t base);
		int v;
		case (tex)
			TEXTURE_SMOOTH: begin
				v = int'(base) + int'($urandom_range(18)) - 9;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
			end
			TEXTURE_RAIL: v = $urandom_range(1) ? 255 : 0;
			default: v = $urandom_range(255);
		endcase
		return lbp3d_pkg::pix_t'(v);
	endfunction

	// Streams count pixels of one texture. A fresh run opens with frame_start;
	// a noisy one also drops a stray frame_start in now and then, which
	// restarts the frame in the middle of a row.
	task automatic send_run(input int unsigned count, input bit fresh, input bit noisy);
		texture_t        tex;
		lbp3d_pkg::pix_t base;
		bit              fs;
		tex  = texture_t'($urandom_range(2));
		base = lbp3d_pkg::pix_t'($urandom_range(255));
		for (int unsigned k = 0; k < count; k++) begin
			fs = (fresh && k == 0) || (noisy && $urandom_range(99) < 2);
			push_pixel(pick_pixel(tex, base), fs);
		end
	endtask

	initial begin
		// Directed windows at the narrowest width. The first frame puts a black
		// centre among white neighbours and then a white centre with mixed
		// neighbours; the second, restarted by frame_start, holds differences
		// of zero to five, seven and eight around a centre of 100 to show saturation.
		lbp3d_pkg::pix_t               directed_px [21] = '{
			8'd255, 8'd255, 8'd255,
			8'd255, 8'd0,   8'd255,
			8'd255, 8'd255, 8'd255,
			8'd0,   8'd0,   8'd0,
			8'd101, 8'd102, 8'd103,
			8'd108, 8'd100, 8'd93,
			8'd96,  8'd95,  8'd100};
		int unsigned                   rand_items;
		int unsigned                   span;
		int unsigned                   count;
		int unsigned                   pick;
		int unsigned                   runs;
		logic [lbp3d_pkg::WIDTH_W-1:0] w;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The width after reset is 640, so the first 45 pixels stay in row 0.
		// Width then shrinks in mid row: the column counter already stands past
		// the new last column, so the next pixel closes the row, and the rows
		// of the following results show the new width.
		send_run(45, 1'b1, 1'b0);
		write_width(lbp3d_pkg::WIDTH_W'(20));
		send_run(3 * 20 + 15, 1'b0, 1'b0);
		write_width(lbp3d_pkg::WIDTH_W'(9));
		send_run(1 + 4 * 9, 1'b0, 1'b0);

		// A width of zero acts as the minimum of three.
		write_width('0);
		foreach (directed_px[i])
			push_pixel(directed_px[i], i == 0 || i == 12);

		// Random part: mostly whole frames with random content at assorted
		// widths, some cut short and some hit by a stray frame_start. One
		// stretch runs with no idle cycles on either side.
		rand_items = 0;
		while (rand_items < 1000) begin
			calm = (rand_items >= 300 && rand_items < 650);
			pick = $urandom_range(9);
			if (pick == 0)
				w = lbp3d_pkg::WIDTH_W'($urandom_range(2));
			else if (pick == 9)
				w = lbp3d_pkg::WIDTH_W'($urandom_range(130, 60));
			else
				w = lbp3d_pkg::WIDTH_W'($urandom_range(24, 3));
			span = span_of(w);
			write_width(w);
			runs = (span > 40) ? 1 : $urandom_range(3, 1);
			repeat (runs) begin
				count = span * $urandom_range((span > 40) ? 4 : 7, 3);
				if ($urandom_range(9) == 0)
					count -= $urandom_range(span, 1);
				send_run(count, 1'b1, 1'b1);
				rand_items += count;
			end
		end
		calm = 1'b0;

		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (due_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (chk_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/lbp3d_pkg.sv
sv/lbp3d_line_store.sv
sv/lbp3d_window.sv
sv/lbp3d_window_encoder.sv
verif/lbp3d_code_checker.sv
verif/tb_lbp3d_window_encoder.sv
